### design/sptm_pkg.sv
`default_nettype none
package sptm_pkg;

  localparam int unsigned MaxPointsDefault = 1024;
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned TolW = 16;
  localparam logic [TolW-1:0] TolReset = 16'd1;

  localparam logic [2:0] OpClear = 3'd0;
  localparam logic [2:0] OpAppend = 3'd1;
  localparam logic [2:0] OpSort = 3'd2;
  localparam logic [2:0] OpMatch = 3'd3;
  localparam logic [2:0] OpRead = 3'd4;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusRange = 2'd2;

  typedef struct packed {
    logic [2:0]        operation;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [IdxW-1:0]   entry_index;
    logic              start_given;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [IdxW-1:0]    result_index;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [CountW-1:0]  point_count;
  } out_word_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } point_t;

  // comparison result
  typedef enum logic [1:0] {
    CmpEq   = 2'd0,
    CmpLess = 2'd1,
    CmpMore = 2'd2
  } cmp_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdA,      // issue read of first operand
    StRdB,      // issue read of entry j (match/read)
    StCmp,      // compare registered data
    StSwapA,
    StSwapB,
    StOut
  } state_e;

  // datapath commands
  typedef enum logic [3:0] {
    DpNone,
    DpLoad,     // capture input word
    DpRdPtr,    // read mem at ptr
    DpRdPrev,   // read mem at ptr-1
    DpCapA,     // capture read data into a
    DpWrPtrB,   // write b at ptr
    DpWrPrevA,  // write a at ptr-1
    DpAppend
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
  } dp_ctrl_t;

  function automatic cmp_e cmp_coord(input logic [CoordW-1:0] a,
                                     input logic [CoordW-1:0] b,
                                     input logic [TolW-1:0] tol);
    logic signed [CoordW:0] d;
    logic signed [CoordW:0] t;
    begin
      d = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
      t = $signed({{(CoordW+1-TolW){1'b0}}, tol});
      if (d > t) cmp_coord = CmpMore;
      else if (d < -t) cmp_coord = CmpLess;
      else cmp_coord = CmpEq;
    end
  endfunction

endpackage
`default_nettype wire

### design/sorted_point_table_match_core.sv
`default_nettype none
// channel  | direction | signals
// in       | input     | in_valid_i, in_ready_o, in_word_i
// out      | output    | out_valid_o, out_ready_i, out_word_o
// cfg      | input     | cfg_valid_i, cfg_ready_o, cfg_tolerance_i
// clear, append: answer from idle; read: one entry; match: one read per entry walked
// sort: each entry after the first is read into a and swapped down past larger entries
// until a compare stops it or it reaches entry 0 (insertion sort over the point memory)
// result is held in an output register; input waits while busy or the result is unread
// asynchronous active-low reset empties the table and sets tolerance to 1
module sorted_point_table_match_core #(
  parameter int unsigned MaxPoints = sptm_pkg::MaxPointsDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire sptm_pkg::in_word_t    in_word_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      sptm_pkg::out_word_t   out_word_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [sptm_pkg::TolW-1:0] cfg_tolerance_i
);
  import sptm_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  logic [TolW-1:0] tol_q;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  point_t wdata, rdata, a;
  cmp_e cmp;
  logic cnt_clr, cnt_inc;
  logic [CntW-1:0] cnt;

  // tolerance register, always writable
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_tolerance_i;
    end
  end

  sptm_ctrl #(.MaxPoints(MaxPoints)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr),
    .rdata_i(rdata), .a_o(a), .cmp_i(cmp),
    .cnt_clr_o(cnt_clr), .cnt_inc_o(cnt_inc), .cnt_i(cnt)
  );

  sptm_dp #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata), .a_i(a), .tol_i(tol_q), .cmp_o(cmp),
    .cnt_clr_i(cnt_clr), .cnt_inc_i(cnt_inc), .cnt_o(cnt)
  );
endmodule
`default_nettype wire

### design/sptm_dp.sv
`default_nettype none
module sptm_dp #(
  parameter int unsigned MaxPoints = sptm_pkg::MaxPointsDefault,
  parameter int unsigned AddrW = $clog2(MaxPoints),
  parameter int unsigned CntW = $clog2(MaxPoints + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  we_i,
  input  wire logic [AddrW-1:0]      waddr_i,
  input  wire sptm_pkg::point_t      wdata_i,
  input  wire logic [AddrW-1:0]      raddr_i,
  output      sptm_pkg::point_t      rdata_o,
  input  wire sptm_pkg::point_t      a_i,
  input  wire logic [sptm_pkg::TolW-1:0] tol_i,
  output      sptm_pkg::cmp_e        cmp_o,
  input  wire logic                  cnt_clr_i,
  input  wire logic                  cnt_inc_i,
  output      logic [CntW-1:0]       cnt_o
);
  import sptm_pkg::*;

  point_t mem [MaxPoints];
  point_t rdata_q;
  logic [CntW-1:0] cnt_q;
  cmp_e cx, cy, cz;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cnt_clr_i) begin
      cnt_q <= '0;
    end else if (cnt_inc_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // lexicographic compare of a against stored word
  always_comb begin
    cx = cmp_coord(a_i.x, rdata_q.x, tol_i);
    cy = cmp_coord(a_i.y, rdata_q.y, tol_i);
    cz = cmp_coord(a_i.z, rdata_q.z, tol_i);
    if (cx != CmpEq) cmp_o = cx;
    else if (cy != CmpEq) cmp_o = cy;
    else cmp_o = cz;
  end

  assign rdata_o = rdata_q;
  assign cnt_o = cnt_q;
endmodule
`default_nettype wire

### design/sptm_ctrl.sv
`default_nettype none
module sptm_ctrl #(
  parameter int unsigned MaxPoints = sptm_pkg::MaxPointsDefault,
  parameter int unsigned AddrW = $clog2(MaxPoints),
  parameter int unsigned CntW = $clog2(MaxPoints + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire sptm_pkg::in_word_t  in_word_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      sptm_pkg::out_word_t out_word_o,
  output      logic                we_o,
  output      logic [AddrW-1:0]    waddr_o,
  output      sptm_pkg::point_t    wdata_o,
  output      logic [AddrW-1:0]    raddr_o,
  input  wire sptm_pkg::point_t    rdata_i,
  output      sptm_pkg::point_t    a_o,
  input  wire sptm_pkg::cmp_e      cmp_i,
  output      logic                cnt_clr_o,
  output      logic                cnt_inc_o,
  input  wire logic [CntW-1:0]     cnt_i
);
  import sptm_pkg::*;

  // sort: i outer, j inner; match: ptr walk with direction
  state_e state_q, state_d;
  logic [2:0] op_q, op_d;
  point_t a_q, a_d;
  logic [CntW-1:0] i_q, i_d, j_q, j_d;
  logic dir_q, dir_d;          // 1 walks forward
  logic first_q, first_d;
  out_word_t res_q, res_d;
  logic ov_q, ov_d;
  logic [CntW-1:0] start_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    a_q <= a_d;
    i_q <= i_d;
    j_q <= j_d;
    dir_q <= dir_d;
    first_q <= first_d;
    res_q <= res_d;
  end

  assign start_w = in_word_i.start_given ?
                   CntW'({{(32-IdxW){1'b0}}, in_word_i.entry_index}) : '0;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    a_d = a_q;
    i_d = i_q;
    j_d = j_q;
    dir_d = dir_q;
    first_d = first_q;
    res_d = res_q;
    ov_d = ov_q;
    we_o = 1'b0;
    waddr_o = j_q[AddrW-1:0];
    wdata_o = a_q;
    raddr_o = j_q[AddrW-1:0];
    cnt_clr_o = 1'b0;
    cnt_inc_o = 1'b0;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (state_q)
      StIdle: begin
        in_ready_o = !ov_q || out_ready_i;
        if (in_valid_i && in_ready_o) begin
          op_d = in_word_i.operation;
          a_d = '{x: in_word_i.coord_x, y: in_word_i.coord_y, z: in_word_i.coord_z};
          res_d = '0;
          res_d.point_count = CountW'(cnt_i);
          case (in_word_i.operation)
            OpClear: begin
              cnt_clr_o = 1'b1;
              res_d.point_count = '0;
              ov_d = 1'b1;
            end
            OpAppend: begin
              if (cnt_i >= CntW'(MaxPoints)) begin
                res_d.status = StatusFull;
              end else begin
                we_o = 1'b1;
                waddr_o = cnt_i[AddrW-1:0];
                wdata_o = a_d;
                cnt_inc_o = 1'b1;
                res_d.result_index = IdxW'(cnt_i);
                res_d.point_count = CountW'(cnt_i + 1'b1);
              end
              ov_d = 1'b1;
            end
            OpSort: begin
              if (cnt_i > CntW'(1)) begin
                i_d = CntW'(1);
                j_d = CntW'(1);
                state_d = StRdA;
              end else begin
                ov_d = 1'b1;
              end
            end
            OpMatch: begin
              if (start_w >= cnt_i) begin
                res_d.status = StatusRange;
                ov_d = 1'b1;
              end else begin
                j_d = start_w;
                first_d = 1'b1;
                state_d = StRdB;
              end
            end
            OpRead: begin
              if (CntW'({{(32-IdxW){1'b0}}, in_word_i.entry_index}) >= cnt_i) begin
                res_d.status = StatusRange;
                ov_d = 1'b1;
              end else begin
                j_d = CntW'({{(32-IdxW){1'b0}}, in_word_i.entry_index});
                state_d = StRdB;
              end
            end
            default: ov_d = 1'b1;
          endcase
        end
      end
      // sort: load entry j into a
      StRdA: begin
        raddr_o = j_q[AddrW-1:0];
        state_d = StSwapA;
      end
      StSwapA: begin
        a_d = rdata_i;
        raddr_o = AddrW'(j_q - 1'b1);
        state_d = StCmp;
      end
      // issue read at j (match/read)
      StRdB: begin
        raddr_o = j_q[AddrW-1:0];
        state_d = StCmp;
      end
      StCmp: begin
        if (op_q == OpSort) begin
          // a holds entry j, rdata holds entry j-1
          if (cmp_i == CmpLess) begin
            we_o = 1'b1;
            waddr_o = j_q[AddrW-1:0];
            wdata_o = rdata_i;
            state_d = StSwapB;
          end else begin
            state_d = StOut; // next outer
          end
        end else if (op_q == OpRead) begin
          res_d.result_index = IdxW'(j_q);
          res_d.out_x = rdata_i.x;
          res_d.out_y = rdata_i.y;
          res_d.out_z = rdata_i.z;
          ov_d = 1'b1;
          state_d = StIdle;
        end else begin
          if (cmp_i == CmpEq) begin
            res_d.found = 1'b1;
            res_d.result_index = IdxW'(j_q);
            res_d.out_x = rdata_i.x;
            res_d.out_y = rdata_i.y;
            res_d.out_z = rdata_i.z;
            ov_d = 1'b1;
            state_d = StIdle;
          end else if (first_q) begin
            first_d = 1'b0;
            dir_d = (cmp_i == CmpMore);
            if (cmp_i == CmpMore) begin
              if (j_q + 1'b1 >= cnt_i) begin
                ov_d = 1'b1;
                state_d = StIdle;
              end else begin
                j_d = j_q + 1'b1;
                state_d = StRdB;
              end
            end else if (j_q == '0) begin
              ov_d = 1'b1;
              state_d = StIdle;
            end else begin
              j_d = j_q - 1'b1;
              state_d = StRdB;
            end
          end else if (dir_q) begin
            if (cmp_i == CmpLess || j_q + 1'b1 >= cnt_i) begin
              ov_d = 1'b1;
              state_d = StIdle;
            end else begin
              j_d = j_q + 1'b1;
              state_d = StRdB;
            end
          end else begin
            if (cmp_i == CmpMore || j_q == '0) begin
              ov_d = 1'b1;
              state_d = StIdle;
            end else begin
              j_d = j_q - 1'b1;
              state_d = StRdB;
            end
          end
        end
      end
      // finish swap: moving entry goes to j-1
      StSwapB: begin
        we_o = 1'b1;
        waddr_o = AddrW'(j_q - 1'b1);
        wdata_o = a_q;
        if (j_q == CntW'(1)) begin
          state_d = StOut;
        end else begin
          j_d = j_q - 1'b1;
          raddr_o = AddrW'(j_q - 2'd2);
          state_d = StCmp;
        end
      end
      // advance outer index of sort
      StOut: begin
        if (i_q + 1'b1 >= cnt_i) begin
          ov_d = 1'b1;
          state_d = StIdle;
        end else begin
          i_d = i_q + 1'b1;
          j_d = i_q + 1'b1;
          state_d = StRdA;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_word_o = res_q;
  assign a_o = a_q;
endmodule
`default_nettype wire
